@@ design/btas_pkg.sv @@
// Shared types and constants for the block transfer address sequencer.
// Used by the controller, the datapath, the top level and the checker.
package btas_pkg;

	// Register file size and the index of the program counter.
	localparam int NUM_REGS  = 16;
	localparam int PC_IDX    = NUM_REGS - 1;
	localparam int CNT_W     = $clog2(NUM_REGS + 1);
	localparam int BYTES_W   = CNT_W + 2;
	localparam int WORD_BYTES = 4;
	localparam int EMPTY_BYTES = NUM_REGS * WORD_BYTES;

	// Fixed field widths.
	localparam int IDX_W  = 4;
	localparam int LIST_W = 16;
	localparam int ADDR_W = 32;

	// Request payload layout, lowest bit first.
	localparam int IN_PRE    = 0;
	localparam int IN_INC    = 1;
	localparam int IN_SREQ   = 2;
	localparam int IN_WB     = 3;
	localparam int IN_LD     = 4;
	localparam int IN_BIDX   = 5;
	localparam int IN_LIST   = 9;
	localparam int IN_BASE   = 25;
	localparam int IN_SAVED  = 57;
	localparam int IN_DATA_W = 64;

	// Result payload layout, lowest bit first.
	localparam int OUT_REG     = 0;
	localparam int OUT_ADDR    = 4;
	localparam int OUT_LD      = 36;
	localparam int OUT_WB      = 37;
	localparam int OUT_BTGT    = 38;
	localparam int OUT_NBASE   = 42;
	localparam int OUT_UBANK   = 74;
	localparam int OUT_RESTORE = 75;
	localparam int OUT_FLUSH   = 76;
	localparam int OUT_DATA_W  = 80;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;
		logic setup;
		logic emit;
	} btas_cmd_t;

	// Datapath status back to the controller.
	typedef struct packed {
		logic last;
	} btas_status_t;

	// Number of set bits in a register list.
	function automatic logic [CNT_W-1:0] popcount(input logic [NUM_REGS-1:0] list);
		logic [CNT_W-1:0] cnt;
		cnt = '0;
		for (int i = 0; i < NUM_REGS; i++) begin
			cnt = cnt + CNT_W'(list[i]);
		end
		return cnt;
	endfunction

endpackage

@@ design/block_transfer_address_sequencer.sv @@
// Top level of the block transfer address sequencer (load/store multiple).
// Instantiates btas_ctrl and btas_dp; uses btas_pkg.
//
// Usage:
// The slave channel takes one decoded load/store-multiple request with the
// base register value. The master channel returns one request per listed
// register, lowest index first, with its word address, direction, base
// writeback on the first beat and status restore / flush on the last beat
// (m_tlast). An empty list transfers only the program counter and moves the
// base by 64 bytes.
// The request is captured on acceptance, addresses and the new base are set
// up in the next cycle, then the sequencer emits one transfer per cycle into
// the output register whenever that register is free, pausing while the
// receiver stalls.
// s_tready is high only while the sequencer is idle; it may take the next
// request while the final result still waits in the output register.
// When the receiver stalls, the output register holds its result and the
// emission loop waits. Reset returns the sequencer to idle with no result
// pending; nothing else needs to clear.
module block_transfer_address_sequencer import btas_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// Fields from bit 0: pre_index, increment, user_bank_req, writeback,
	// is_load, base_index[3:0], register_list[15:0], base_value[31:0],
	// mode_has_saved_status, zero fill.
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// Fields from bit 0: reg_index[3:0], address[31:0], load_access,
	// write_base, base_target[3:0], new_base[31:0], user_bank,
	// restore_status, flush_pipeline, zero fill.
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	btas_cmd_t    cmd;
	btas_status_t status;

	// Sequencing control.
	btas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Address and register selection datapath.
	btas_dp u_dp (
		.clk     (clk),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.status  (status),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

@@ design/btas_ctrl.sv @@
// Controller state machine of the block transfer address sequencer.
// Depends on btas_pkg for the command and status structs.
module btas_ctrl import btas_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  btas_status_t status,
	output btas_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd.load  = (state_q == ST_IDLE) && s_tvalid;
		cmd.setup = (state_q == ST_SETUP);
		cmd.emit  = (state_q == ST_EMIT) && out_free;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free && status.last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/btas_dp.sv @@
// Datapath of the block transfer address sequencer: request registers,
// address stepping, register selection and the output register. Uses btas_pkg.
module btas_dp import btas_pkg::*; (
	input  logic                  clk,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  btas_cmd_t             cmd,
	output btas_status_t          status,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	// Request fields, captured on acceptance.
	logic                pre_q, inc_q, sreq_q, wb_q, ld_q, saved_q;
	logic [IDX_W-1:0]    bidx_q;
	logic [NUM_REGS-1:0] list_q;
	logic [ADDR_W-1:0]   base_q;

	// Per-instruction working state.
	logic              ubank_q, restore_q, flush_q, first_q;
	logic [ADDR_W-1:0] addr_q, nbase_q;

	// Output register.
	logic [IDX_W-1:0]  o_reg_q, o_btgt_q;
	logic [ADDR_W-1:0] o_addr_q, o_nbase_q;
	logic              o_ld_q, o_wb_q, o_ubank_q, o_restore_q, o_flush_q, o_last_q;

	// Setup arithmetic.
	logic [NUM_REGS-1:0] list_eff;
	logic [BYTES_W-1:0]  bytes;
	logic [ADDR_W-1:0]   bytes_ext;
	logic                pc_in;

	always_comb begin
		if (list_q == '0) begin
			list_eff = NUM_REGS'(1) << PC_IDX;
			bytes    = BYTES_W'(EMPTY_BYTES);
		end else begin
			list_eff = list_q;
			bytes    = {popcount(list_q), 2'b00};
		end
		bytes_ext = ADDR_W'(bytes);
		pc_in     = list_eff[PC_IDX];
	end

	// Lowest listed register and what remains after it.
	logic [NUM_REGS-1:0] low_bit, rest;
	logic [IDX_W-1:0]    sel_idx;
	logic [ADDR_W-1:0]   addr_next, addr_out;

	always_comb begin
		low_bit = list_q & (~list_q + NUM_REGS'(1));
		rest    = list_q & ~low_bit;
		sel_idx = '0;
		for (int i = 0; i < NUM_REGS; i++) begin
			if (low_bit[i]) sel_idx = sel_idx | IDX_W'(i);
		end
		addr_next = addr_q + ADDR_W'(WORD_BYTES);
		addr_out  = pre_q ? addr_next : addr_q;
	end

	assign status.last = (rest == '0);

	// Request capture, setup and stepping.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pre_q   <= s_tdata[IN_PRE];
			inc_q   <= s_tdata[IN_INC];
			sreq_q  <= s_tdata[IN_SREQ];
			wb_q    <= s_tdata[IN_WB];
			ld_q    <= s_tdata[IN_LD];
			bidx_q  <= s_tdata[IN_BIDX +: IDX_W];
			list_q  <= s_tdata[IN_LIST +: NUM_REGS];
			base_q  <= s_tdata[IN_BASE +: ADDR_W];
			saved_q <= s_tdata[IN_SAVED];
		end else if (cmd.setup) begin
			// Descending modes start at the lowest address and swap before/after.
			list_q    <= list_eff;
			pre_q     <= inc_q ? pre_q : !pre_q;
			addr_q    <= inc_q ? base_q : base_q - bytes_ext;
			nbase_q   <= inc_q ? base_q + bytes_ext : base_q - bytes_ext;
			ubank_q   <= sreq_q && (!ld_q || !pc_in) && saved_q;
			restore_q <= ld_q && pc_in && sreq_q && saved_q;
			flush_q   <= ld_q && pc_in;
			first_q   <= 1'b1;
		end else if (cmd.emit) begin
			list_q  <= rest;
			addr_q  <= addr_next;
			first_q <= 1'b0;
		end
	end

	// Output register, loaded with one transfer per emit.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			o_reg_q     <= sel_idx;
			o_addr_q    <= addr_out;
			o_ld_q      <= ld_q;
			o_wb_q      <= first_q && wb_q;
			o_btgt_q    <= (first_q && wb_q) ? bidx_q : '0;
			o_nbase_q   <= (first_q && wb_q) ? nbase_q : '0;
			o_ubank_q   <= ubank_q;
			o_restore_q <= status.last && restore_q;
			o_flush_q   <= status.last && flush_q;
			o_last_q    <= status.last;
		end
	end

	always_comb begin
		m_tdata                        = '0;
		m_tdata[OUT_REG +: IDX_W]      = o_reg_q;
		m_tdata[OUT_ADDR +: ADDR_W]    = o_addr_q;
		m_tdata[OUT_LD]                = o_ld_q;
		m_tdata[OUT_WB]                = o_wb_q;
		m_tdata[OUT_BTGT +: IDX_W]     = o_btgt_q;
		m_tdata[OUT_NBASE +: ADDR_W]   = o_nbase_q;
		m_tdata[OUT_UBANK]             = o_ubank_q;
		m_tdata[OUT_RESTORE]           = o_restore_q;
		m_tdata[OUT_FLUSH]             = o_flush_q;
	end

	assign m_tlast = o_last_q;

endmodule

@@ design/btas_chk.sv @@
// Port-level checker for the block transfer address sequencer, bound to the top.
// Uses btas_pkg for the result payload layout.
module btas_chk import btas_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	// A stalled result holds still.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// One instruction at a time: a taken request closes the slave side.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// Status restore and flush appear only on the final transfer.
	a_last_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[OUT_RESTORE] || m_tdata[OUT_FLUSH]) |-> m_tlast)
		else $error("restore or flush before the last transfer");

	// Restore implies a program counter load and thus a flush.
	a_restore_flush: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_RESTORE] |-> m_tdata[OUT_FLUSH] && m_tdata[OUT_LD])
		else $error("restore without a program counter load");

	// Base writeback rides only on the first transfer.
	a_wb_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !(m_tvalid && m_tdata[OUT_WB]))
		else $error("base writeback after the first transfer");

endmodule

bind block_transfer_address_sequencer btas_chk u_btas_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

@@ tb/block_transfer_address_sequencer_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for block_transfer_address_sequencer.
// Needs btas_pkg and the sequencer RTL. Directed table first, then random instructions.
module block_transfer_address_sequencer_test;
	import btas_pkg::*;

	// One decoded load/store-multiple instruction.
	typedef struct packed {
		logic              pre_index;
		logic              increment;
		logic              user_bank_req;
		logic              writeback;
		logic              is_load;
		logic [IDX_W-1:0]  base_index;
		logic [LIST_W-1:0] register_list;
		logic [ADDR_W-1:0] base_value;
		logic              mode_has_saved_status;
	} lsm_instr_t;

	// One register transfer leaving the sequencer.
	typedef struct packed {
		logic [IDX_W-1:0]  reg_index;
		logic [ADDR_W-1:0] address;
		logic              load_access;
		logic              write_base;
		logic [IDX_W-1:0]  base_target;
		logic [ADDR_W-1:0] new_base;
		logic              user_bank;
		logic              restore_status;
		logic              flush_pipeline;
		logic              last;
	} transfer_t;

	// Directed row: when typed is set the single expected transfer is given here.
	typedef struct packed {
		lsm_instr_t ins;
		logic       typed;
		transfer_t  beat;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	transfer_t     expected_transfers[$];
	directed_row_t directed_rows[$];
	int            fail_count = 0;
	bit            no_stalls = 1'b0;

	block_transfer_address_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the sequencer hangs.
	initial begin
		#400000;
		$display("** block_transfer_address_sequencer: FAILED **");
		$finish;
	end

	function automatic lsm_instr_t lsm_instr(input int pre, input int inc,
			input int sreq, input int wb, input int ld, input int bidx,
			input logic [15:0] list, input logic [31:0] base, input int saved);
		return '{1'(pre), 1'(inc), 1'(sreq), 1'(wb), 1'(ld), IDX_W'(bidx), list, base,
			1'(saved)};
	endfunction

	function automatic transfer_t xfer_beat(input int idx, input logic [31:0] addr,
			input int ld, input int wb, input int tgt, input logic [31:0] nbase,
			input int ub, input int rs, input int fl, input int fin);
		return '{IDX_W'(idx), addr, 1'(ld), 1'(wb), IDX_W'(tgt), nbase, 1'(ub), 1'(rs),
			1'(fl), 1'(fin)};
	endfunction

	// Stalls with a chance of 29 in 100 per call, except during the quiet stretch.
	function automatic bit take_break();
		return !no_stalls && ($urandom_range(99) < 29);
	endfunction

	// Expands one instruction into the transfers it should produce, in order.
	function automatic void predict_transfers(input lsm_instr_t ins);
		logic [LIST_W-1:0] list;
		logic [ADDR_W-1:0] bytes;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] nbase;
		logic              step_first;
		logic              pc_in;
		logic              ubank;
		logic              restore;
		logic              flush;
		int                total;
		int                n;
		transfer_t         t;
		// List bits beyond the register file are ignored.
		list = ins.register_list & LIST_W'((1 << NUM_REGS) - 1);
		total = $countones(list);
		// An empty list moves only the program counter but steps the base a full bank.
		if (list == '0) begin
			list = LIST_W'(1) << PC_IDX;
			bytes = ADDR_W'(EMPTY_BYTES);
			total = 1;
		end else begin
			bytes = ADDR_W'(WORD_BYTES * total);
		end
		pc_in = list[PC_IDX];
		ubank = ins.user_bank_req && (!ins.is_load || !pc_in) && ins.mode_has_saved_status;
		restore = ins.is_load && pc_in && ins.user_bank_req && ins.mode_has_saved_status;
		flush = ins.is_load && pc_in;
		// Descending modes start at the bottom of the block with the stepping sense flipped.
		if (ins.increment) begin
			step_first = ins.pre_index;
			addr = ins.base_value;
			nbase = ins.base_value + bytes;
		end else begin
			step_first = !ins.pre_index;
			addr = ins.base_value - bytes;
			nbase = ins.base_value - bytes;
		end
		n = 0;
		for (int r = 0; r < NUM_REGS; r++) begin
			if (list[r]) begin
				if (step_first)
					addr = addr + ADDR_W'(WORD_BYTES);
				t.reg_index = IDX_W'(r);
				t.address = addr;
				t.load_access = ins.is_load;
				t.write_base = (n == 0) && ins.writeback;
				t.base_target = t.write_base ? ins.base_index : '0;
				t.new_base = t.write_base ? nbase : '0;
				t.user_bank = ubank;
				t.restore_status = (n == total - 1) && restore;
				t.flush_pipeline = (n == total - 1) && flush;
				t.last = (n == total - 1);
				expected_transfers.push_back(t);
				if (!step_first)
					addr = addr + ADDR_W'(WORD_BYTES);
				n++;
			end
		end
	endfunction

	// Offers one request and returns at the edge where it is taken.
	task automatic send_instr(input lsm_instr_t ins, input logic typed, input transfer_t beat);
		logic [IN_DATA_W-1:0] d;
		while (take_break()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		d = '0;
		d[IN_PRE] = ins.pre_index;
		d[IN_INC] = ins.increment;
		d[IN_SREQ] = ins.user_bank_req;
		d[IN_WB] = ins.writeback;
		d[IN_LD] = ins.is_load;
		d[IN_BIDX +: IDX_W] = ins.base_index;
		d[IN_LIST +: LIST_W] = ins.register_list;
		d[IN_BASE +: ADDR_W] = ins.base_value;
		d[IN_SAVED] = ins.mode_has_saved_status;
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do
			@(posedge clk);
		while (!s_tready);
		if (typed)
			expected_transfers.push_back(beat);
		else
			predict_transfers(ins);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Receiver backpressure.
	always @(posedge clk) begin
		m_tready <= !take_break();
	end

	// Compare every accepted transfer against the oldest expectation.
	always @(posedge clk) begin : result_check
		transfer_t got;
		transfer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.reg_index = m_tdata[OUT_REG +: IDX_W];
			got.address = m_tdata[OUT_ADDR +: ADDR_W];
			got.load_access = m_tdata[OUT_LD];
			got.write_base = m_tdata[OUT_WB];
			got.base_target = m_tdata[OUT_BTGT +: IDX_W];
			got.new_base = m_tdata[OUT_NBASE +: ADDR_W];
			got.user_bank = m_tdata[OUT_UBANK];
			got.restore_status = m_tdata[OUT_RESTORE];
			got.flush_pipeline = m_tdata[OUT_FLUSH];
			got.last = m_tlast;
			if (expected_transfers.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, got %h", $time, got);
				fail_count++;
			end else begin
				want = expected_transfers.pop_front();
				check_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
				check_field("address", want.address, got.address);
				check_field("load_access", 32'(want.load_access), 32'(got.load_access));
				check_field("write_base", 32'(want.write_base), 32'(got.write_base));
				check_field("base_target", 32'(want.base_target), 32'(got.base_target));
				check_field("new_base", want.new_base, got.new_base);
				check_field("user_bank", 32'(want.user_bank), 32'(got.user_bank));
				check_field("restore_status", 32'(want.restore_status),
					32'(got.restore_status));
				check_field("flush_pipeline", 32'(want.flush_pipeline),
					32'(got.flush_pipeline));
				check_field("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	// Stimulus: directed table, then random instructions, then drain.
	initial begin
		lsm_instr_t ins;
		int         k;
		logic [15:0] list;
		logic [31:0] base;

		// Single-transfer rows whose result is typed in: empty list, wrap at both ends,
		// status restore with and without a saved status register.
		directed_rows.push_back('{lsm_instr(0, 1, 0, 1, 1, 0, 16'h0000, 32'h0000_1000, 0), 1'b1,
			xfer_beat(15, 32'h0000_1000, 1, 1, 0, 32'h0000_1040, 0, 0, 1, 1)});
		directed_rows.push_back('{lsm_instr(1, 0, 0, 1, 0, 15, 16'h0001, 32'h0000_0000, 0), 1'b1,
			xfer_beat(0, 32'hFFFF_FFFC, 0, 1, 15, 32'hFFFF_FFFC, 0, 0, 0, 1)});
		directed_rows.push_back('{lsm_instr(1, 1, 1, 0, 1, 5, 16'h8000, 32'hFFFF_FFFF, 1), 1'b1,
			xfer_beat(15, 32'h0000_0003, 1, 0, 0, 32'h0, 0, 1, 1, 1)});
		directed_rows.push_back('{lsm_instr(0, 0, 1, 1, 0, 3, 16'h8000, 32'hFFFF_FFFF, 1), 1'b1,
			xfer_beat(15, 32'hFFFF_FFFF, 0, 1, 3, 32'hFFFF_FFFB, 1, 0, 0, 1)});
		directed_rows.push_back('{lsm_instr(0, 1, 1, 0, 1, 0, 16'h8000, 32'h1234_5678, 0), 1'b1,
			xfer_beat(15, 32'h1234_5678, 1, 0, 0, 32'h0, 0, 0, 1, 1)});
		// Rows checked by the predictor: all four modes, full lists, base in the list,
		// unaligned bases, user bank loads and empty lists with each direction.
		directed_rows.push_back('{lsm_instr(0, 1, 1, 1, 1, 4, 16'hFFFF, 32'h0000_0100, 1), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(1, 0, 1, 1, 0, 0, 16'hFFFF, 32'h0000_0000, 1), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(1, 1, 1, 1, 1, 2, 16'h7FFF, 32'h0000_2000, 1), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(0, 0, 0, 1, 0, 0, 16'h0011, 32'h0000_1003, 0), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(0, 1, 0, 1, 0, 15, 16'hAAAA, 32'h8000_0000, 1), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(1, 0, 0, 0, 1, 7, 16'h5555, 32'hFFFF_FFFF, 0), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(0, 0, 1, 1, 1, 1, 16'h8001, 32'h0000_0040, 0), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(1, 0, 1, 1, 0, 9, 16'h0000, 32'h0000_0020, 1), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(1, 1, 1, 1, 1, 13, 16'h0000, 32'hFFFF_FFF0, 1), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(1, 1, 0, 0, 1, 0, 16'hFFFF, 32'hFFFF_FFC0, 0), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(0, 1, 1, 1, 0, 8, 16'h0100, 32'h0000_0002, 0), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(1, 1, 0, 1, 1, 14, 16'h4000, 32'h7FFF_FFFE, 1), 1'b0, '0});
		directed_rows.push_back('{lsm_instr(0, 0, 1, 0, 1, 6, 16'hC0C0, 32'h0000_1001, 1), 1'b0, '0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_instr(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].beat);

		for (int i = 0; i < 450; i++) begin
			// Both sides run without stalls for a while in the middle.
			no_stalls = (i >= 150) && (i < 230);
			k = $urandom_range(99);
			if (k < 8)
				list = 16'h0000;
			else if (k < 20)
				list = 16'h0001 << $urandom_range(15);
			else if (k < 28)
				list = 16'hFFFF;
			else if (k < 40)
				list = 16'h8000 | 16'($urandom);
			else
				list = 16'($urandom);
			k = $urandom_range(99);
			if (k < 10)
				base = 32'($urandom_range(63));
			else if (k < 20)
				base = 32'hFFFF_FFFF - 32'($urandom_range(63));
			else if (k < 70)
				base = $urandom & 32'hFFFF_FFFC;
			else
				base = $urandom;
			ins = lsm_instr($urandom_range(1), $urandom_range(1), $urandom_range(1),
				$urandom_range(1), $urandom_range(1), $urandom_range(15), list, base,
				$urandom_range(1));
			send_instr(ins, 1'b0, '0);
		end
		no_stalls = 1'b0;
		s_tvalid <= 1'b0;

		// Let every outstanding transfer arrive, then watch for strays.
		while (expected_transfers.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		if (fail_count == 0)
			$display("** block_transfer_address_sequencer: PASSED **");
		else
			$display("** block_transfer_address_sequencer: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
design/btas_pkg.sv
design/btas_ctrl.sv
design/btas_dp.sv
design/block_transfer_address_sequencer.sv
design/btas_chk.sv
tb/block_transfer_address_sequencer_test.sv
